@@ rtl/fpfs_pkg.sv @@
package fpfs_pkg;

	localparam int LOG_FILAMENT_COUNT  = 5;
	localparam int LOG_FILAMENT_LENGTH = 7;
	localparam int IDX_W               = LOG_FILAMENT_COUNT + LOG_FILAMENT_LENGTH;
	localparam int STORE_DEPTH         = 1 << IDX_W;
	localparam int PT_W                = 64;
	localparam int FIX_FRAC            = 10;
	localparam int CFG_ADDR_W          = 3;
	localparam int CFG_DATA_W          = 8;

	localparam logic [CFG_ADDR_W-1:0] REG_LEAD_GAIN   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FOLLOW_GAIN = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_EXPAND_GAIN = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_EULER_SHIFT = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_DEST_PERIOD = 3'd4;

	localparam logic [7:0]  RST_LEAD_GAIN   = 8'd30;
	localparam logic [7:0]  RST_FOLLOW_GAIN = 8'd30;
	localparam logic [7:0]  RST_EXPAND_GAIN = 8'd16;
	localparam logic [3:0]  RST_EULER_SHIFT = 4'd5;
	localparam logic [4:0]  RST_DEST_PERIOD = 5'd6;
	localparam logic [31:0] RST_OSC_X       = 32'h0000_0000;
	localparam logic [31:0] RST_OSC_Y       = 32'hFFFF_FFF0;
	localparam logic [31:0] RST_OSC_Z       = 32'hFFFF_FFFF;

	localparam logic [31:0] FIX_ONE         = 32'(1) << FIX_FRAC;

endpackage

@@ rtl/fpfs_ram.sv @@
module fpfs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/filament_particle_frame_step_unit.sv @@
// Read item: the particle memory is read in S_RD_ISSUE and S_RD_DATA, and the result is loaded in S_DONE.
// Advance item: the walk copies one particle per cycle through the particle memory, and each
// of the 32 heads takes two moves, each led by a bit-serial divide for x and y in parallel
// (skipped when the distance is not positive). One item is in flight at a time.
// After reset the particle memory is zeroed by a clearing pass over all 4096 entries with
// s_tready low; configuration writes are taken during it.
module filament_particle_frame_step_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [15:0]                          s_tdata,  // particle_index[11:0], zero pad
	input  logic [0:0]                           s_tuser,  // func
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// pos_x, pos_y, osc_x, osc_y, osc_z, frame_count (32 bits each, from bit 0 up)
	output logic [191:0]                         m_tdata,
	input  logic                                 cfg_we,
	input  logic [fpfs_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [fpfs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int IW  = fpfs_pkg::IDX_W;
	localparam int LFL = fpfs_pkg::LOG_FILAMENT_LENGTH;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD_ISSUE, S_RD_DATA, S_OSC1, S_OSC2, S_WALK, S_HLOAD,
		S_DIFF, S_MUL, S_DIVINIT, S_DIV, S_APPLY, S_DONE
	} state_t;

	state_t st_q;

	logic [7:0]  lead_gain_q, follow_gain_q, expand_gain_q;
	logic [3:0]  euler_shift_q;
	logic [4:0]  dest_period_q;
	logic [31:0] osc_x_q, osc_y_q, osc_z_q, frame_q;
	logic [31:0] dest_x_q, dest_y_q;
	logic [31:0] yz_q, yy_q;

	logic [IW-1:0] idx_q;
	logic [IW-1:0] s_tdata_idx_q;
	logic          pend_s1;
	logic [IW-1:0] pend_addr_s1;
	logic          mv_q;
	logic [31:0]   px_q, py_q, tx_q, ty_q, gain_q, prev_x_q, prev_y_q;
	logic [31:0]   dx_q, dy_q, nx_q, ny_q, div_s_q;
	logic [31:0]   dvd_x_q, dvd_y_q, qx_q, qy_q;
	logic [32:0]   rem_x_q, rem_y_q;
	logic          neg_x_q, neg_y_q;
	logic [4:0]    bit_q;
	logic          is_read_q;
	logic [31:0]   rd_x_q, rd_y_q;
	logic          out_valid_q;
	logic [191:0]  out_data_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [63:0]   ram_wdata, ram_rdata;

	fpfs_ram #(.WIDTH(fpfs_pkg::PT_W), .DEPTH(fpfs_pkg::STORE_DEPTH)) u_store (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	logic is_head, first_fil, last_idx;
	assign is_head   = &idx_q[LFL-1:0];
	assign first_fil = (idx_q[IW-1:LFL] == '0);
	assign last_idx  = &idx_q;

	// oscillator step, combinational from registered products
	logic [31:0] xn, yn, zn, t_y, t_z;
	assign xn  = osc_x_q + 32'($signed(osc_y_q) >>> euler_shift_q);
	assign t_y = (32'd0 - osc_x_q) + 32'($signed(yz_q) >>> fpfs_pkg::FIX_FRAC);
	assign yn  = osc_y_q + 32'($signed(t_y) >>> euler_shift_q);
	assign t_z = fpfs_pkg::FIX_ONE - 32'($signed(yy_q) >>> fpfs_pkg::FIX_FRAC);
	assign zn  = osc_z_q + 32'($signed(t_z) >>> euler_shift_q);

	logic [31:0] period_mask;
	assign period_mask = ~(32'hFFFF_FFFF << dest_period_q);

	logic [31:0] abs_dx, abs_dy, s_sum;
	assign abs_dx = dx_q[31] ? 32'd0 - dx_q : dx_q;
	assign abs_dy = dy_q[31] ? 32'd0 - dy_q : dy_q;
	assign s_sum  = abs_dx + abs_dy;

	logic [32:0] trial_x, trial_y;
	assign trial_x = {rem_x_q[31:0], dvd_x_q[31]};
	assign trial_y = {rem_y_q[31:0], dvd_y_q[31]};

	logic [31:0] qx_s, qy_s, new_px, new_py;
	assign qx_s   = neg_x_q ? 32'd0 - qx_q : qx_q;
	assign qy_s   = neg_y_q ? 32'd0 - qy_q : qy_q;
	assign new_px = px_q - qx_s;
	assign new_py = py_q - qy_s;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pend_addr_s1;
		ram_wdata = ram_rdata;
		ram_raddr = idx_q + IW'(1);
		unique case (st_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = '0;
			end
			S_RD_ISSUE: ram_raddr = s_tdata_idx_q;
			S_WALK: begin
				ram_we    = pend_s1;
				ram_raddr = is_head ? idx_q : idx_q + IW'(1);
			end
			S_APPLY: begin
				ram_we    = mv_q;
				ram_waddr = idx_q;
				ram_wdata = {new_py, new_px};
			end
			default: ;
		endcase
	end

	assign s_tready = (st_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_gain_q   <= fpfs_pkg::RST_LEAD_GAIN;
			follow_gain_q <= fpfs_pkg::RST_FOLLOW_GAIN;
			expand_gain_q <= fpfs_pkg::RST_EXPAND_GAIN;
			euler_shift_q <= fpfs_pkg::RST_EULER_SHIFT;
			dest_period_q <= fpfs_pkg::RST_DEST_PERIOD;
		end else if (cfg_we) begin
			case (cfg_addr)
				fpfs_pkg::REG_LEAD_GAIN:   lead_gain_q   <= cfg_wdata;
				fpfs_pkg::REG_FOLLOW_GAIN: follow_gain_q <= cfg_wdata;
				fpfs_pkg::REG_EXPAND_GAIN: expand_gain_q <= cfg_wdata;
				fpfs_pkg::REG_EULER_SHIFT: euler_shift_q <= cfg_wdata[3:0];
				fpfs_pkg::REG_DEST_PERIOD: dest_period_q <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLEAR;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			osc_x_q     <= fpfs_pkg::RST_OSC_X;
			osc_y_q     <= fpfs_pkg::RST_OSC_Y;
			osc_z_q     <= fpfs_pkg::RST_OSC_Z;
			frame_q     <= '0;
		end else begin
			// the done state reloads the output itself
			if (out_valid_q && m_tready && st_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_CLEAR: begin
					idx_q <= idx_q + IW'(1);
					if (&idx_q) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						s_tdata_idx_q <= s_tdata[IW-1:0];
						is_read_q     <= s_tuser[0];
						st_q          <= s_tuser[0] ? S_RD_ISSUE : S_OSC1;
					end
				end
				S_RD_ISSUE: st_q <= S_RD_DATA;
				S_RD_DATA: begin
					rd_x_q <= ram_rdata[31:0];
					rd_y_q <= ram_rdata[63:32];
					st_q   <= S_DONE;
				end
				S_OSC1: begin
					yz_q <= osc_y_q * osc_z_q;
					yy_q <= osc_y_q * osc_y_q;
					st_q <= S_OSC2;
				end
				S_OSC2: begin
					osc_x_q <= xn;
					osc_y_q <= yn;
					osc_z_q <= zn;
					if ((frame_q & period_mask) == 32'd0) begin
						dest_x_q <= {{21{xn[3]}}, xn[3:0], 7'b000_0000};
						dest_y_q <= {{21{yn[3]}}, yn[3:0], 7'b000_0000};
					end
					idx_q   <= '0;
					pend_s1 <= 1'b0;
					st_q    <= S_WALK;
				end
				S_WALK: begin
					// write the copy read last cycle, read ahead for this index
					if (is_head) begin
						pend_s1 <= 1'b0;
						st_q    <= S_HLOAD;
					end else begin
						pend_s1      <= 1'b1;
						pend_addr_s1 <= idx_q;
						idx_q        <= idx_q + IW'(1);
					end
				end
				S_HLOAD: begin
					px_q <= ram_rdata[31:0];
					py_q <= ram_rdata[63:32];
					mv_q <= 1'b0;
					if (first_fil) begin
						tx_q   <= dest_x_q - 32'($signed(osc_y_q) >>> 2);
						ty_q   <= dest_y_q - 32'($signed(osc_x_q) >>> 2);
						gain_q <= {24'd0, lead_gain_q};
					end else begin
						tx_q   <= prev_x_q;
						ty_q   <= prev_y_q;
						gain_q <= {24'd0, follow_gain_q};
					end
					st_q <= S_DIFF;
				end
				S_DIFF: begin
					dx_q <= px_q - tx_q;
					dy_q <= py_q - ty_q;
					st_q <= S_MUL;
				end
				S_MUL: begin
					nx_q    <= gain_q * dx_q;
					ny_q    <= gain_q * dy_q;
					div_s_q <= s_sum;
					st_q    <= S_DIVINIT;
				end
				S_DIVINIT: begin
					neg_x_q <= nx_q[31];
					neg_y_q <= ny_q[31];
					dvd_x_q <= nx_q[31] ? 32'd0 - nx_q : nx_q;
					dvd_y_q <= ny_q[31] ? 32'd0 - ny_q : ny_q;
					rem_x_q <= '0;
					rem_y_q <= '0;
					qx_q    <= '0;
					qy_q    <= '0;
					bit_q   <= '0;
					// skip the move when the distance is not positive
					st_q    <= ($signed(div_s_q) > 0) ? S_DIV : S_APPLY;
				end
				S_DIV: begin
					dvd_x_q <= dvd_x_q << 1;
					dvd_y_q <= dvd_y_q << 1;
					if (trial_x >= {1'b0, div_s_q}) begin
						rem_x_q <= trial_x - {1'b0, div_s_q};
						qx_q    <= {qx_q[30:0], 1'b1};
					end else begin
						rem_x_q <= trial_x;
						qx_q    <= {qx_q[30:0], 1'b0};
					end
					if (trial_y >= {1'b0, div_s_q}) begin
						rem_y_q <= trial_y - {1'b0, div_s_q};
						qy_q    <= {qy_q[30:0], 1'b1};
					end else begin
						rem_y_q <= trial_y;
						qy_q    <= {qy_q[30:0], 1'b0};
					end
					bit_q <= bit_q + 5'd1;
					if (&bit_q) begin
						st_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					px_q <= new_px;
					py_q <= new_py;
					if (!mv_q) begin
						mv_q   <= 1'b1;
						tx_q   <= osc_y_q;
						ty_q   <= osc_z_q;
						gain_q <= 32'd0 - {24'd0, expand_gain_q};
						st_q   <= S_DIFF;
					end else begin
						prev_x_q <= new_px;
						prev_y_q <= new_py;
						if (last_idx) begin
							frame_q <= frame_q + 32'd1;
							st_q    <= S_DONE;
						end else begin
							idx_q <= idx_q + IW'(1);
							st_q  <= S_WALK;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {frame_q, osc_z_q, osc_y_q, osc_x_q,
							is_read_q ? rd_y_q : 32'd0, is_read_q ? rd_x_q : 32'd0};
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE) |-> !ram_we)
		else $error("store written while idle");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (st_q != S_IDLE))
		else $error("accepted item not started");

	a_div_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_DIV) |-> ($signed(div_s_q) > 0))
		else $error("divide by non-positive distance");

endmodule
